### hdl/ppwt_pkg.sv
// Package for the planar pose to world transform core.
// Holds the word types, the CORDIC constants and the arctangent table.
// Depends on nothing; used by ppwt_cordic and the top level.
package ppwt_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_COUNT   = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT :
		((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
	localparam int MATH_STAGES  = 3;
	localparam int LATENCY      = CORDIC_ITERS + 1 + MATH_STAGES;

	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] ATAN_TAB [ATAN_COUNT] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
		32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
		32'sd652,       32'sd326,       32'sd163,       32'sd81
	};

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] robot_x;
		logic signed [31:0] robot_y;
		logic        [15:0] heading;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} ppwt_in_t;

	typedef struct packed {
		logic signed [31:0] robot_x;
		logic signed [31:0] robot_y;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} ppwt_side_t;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic               overflowed;
	} ppwt_out_t;

endpackage

### hdl/planar_pose_to_world_transform_core.sv
// Top level of the planar pose to world transform core.
// Rotates a robot-frame point by the heading and adds the robot position.
// Depends on ppwt_pkg and ppwt_cordic.
//
// One word enters on every clock cycle: busy never rises, so a word is taken
// at any edge where start is high. Each result passes through one pre-rotation
// stage, one stage per CORDIC iteration, then a multiply stage, a round stage
// and a saturate stage. The result stands on result for one cycle, marked by
// done; the receiver cannot hold it off, so it must take every word as it comes.
module planar_pose_to_world_transform_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ppwt_pkg::ppwt_in_t  pose,
	output logic                done,
	output ppwt_pkg::ppwt_out_t result
);
	import ppwt_pkg::*;

	logic               c_valid;
	ppwt_side_t         c_side;
	logic signed [31:0] c_cos;
	logic signed [31:0] c_sin;

	logic               v_s1, v_s2, v_s3;
	logic signed [63:0] pxc_s1, pys_s1, pxs_s1, pyc_s1;
	logic signed [31:0] rx_s1, ry_s1, rx_s2, ry_s2;
	logic signed [34:0] tx_s2, ty_s2;
	ppwt_out_t          out_s3;

	logic signed [64:0] sum_x, sum_y;
	logic signed [35:0] wx, wy;
	logic               sat_x, sat_y;

	assign busy = 1'b0;

	ppwt_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_word   (pose),
		.out_valid (c_valid),
		.out_side  (c_side),
		.cos_q     (c_cos),
		.sin_q     (c_sin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= c_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// multiply
	always_ff @(posedge clk) begin
		pxc_s1 <= 64'(c_side.point_x * c_cos);
		pys_s1 <= 64'(c_side.point_y * c_sin);
		pxs_s1 <= 64'(c_side.point_x * c_sin);
		pyc_s1 <= 64'(c_side.point_y * c_cos);
		rx_s1  <= c_side.robot_x;
		ry_s1  <= c_side.robot_y;
	end

	// round to Q16.16, halves upward
	assign sum_x = 65'(pxc_s1) - 65'(pys_s1) + 65'sd536870912;
	assign sum_y = 65'(pxs_s1) + 65'(pyc_s1) + 65'sd536870912;

	always_ff @(posedge clk) begin
		tx_s2 <= sum_x[64:30];
		ty_s2 <= sum_y[64:30];
		rx_s2 <= rx_s1;
		ry_s2 <= ry_s1;
	end

	// add position and saturate
	assign wx    = 36'(rx_s2) + 36'(tx_s2);
	assign wy    = 36'(ry_s2) + 36'(ty_s2);
	assign sat_x = (wx > 36'(SAT_MAX)) || (wx < 36'(SAT_MIN));
	assign sat_y = (wy > 36'(SAT_MAX)) || (wy < 36'(SAT_MIN));

	always_ff @(posedge clk) begin
		out_s3.world_x    <= sat_x ? (wx[35] ? SAT_MIN : SAT_MAX) : wx[31:0];
		out_s3.world_y    <= sat_y ? (wy[35] ? SAT_MIN : SAT_MAX) : wy[31:0];
		out_s3.overflowed <= sat_x || sat_y;
	end

	assign done   = v_s3;
	assign result = out_s3;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching input word");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.overflowed) |->
		(result.world_x == SAT_MAX || result.world_x == SAT_MIN ||
		 result.world_y == SAT_MAX || result.world_y == SAT_MIN))
		else $error("overflow flagged with no coordinate at a limit");

	a_cordic_to_math: assert property (@(posedge clk) disable iff (!arst_n)
		c_valid |-> ##3 done)
		else $error("word lost between rotation and output stages");

endmodule

### hdl/ppwt_cordic.sv
// Pipelined rotation-mode CORDIC: one register stage per iteration.
// Forms cosine and sine of the heading in Q2.30 and carries the pose alongside.
// Depends on ppwt_pkg.
module ppwt_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ppwt_pkg::ppwt_in_t  in_word,
	output logic                out_valid,
	output ppwt_pkg::ppwt_side_t out_side,
	output logic signed [31:0]  cos_q,
	output logic signed [31:0]  sin_q
);
	import ppwt_pkg::*;

	logic               v_s    [CORDIC_ITERS+1];
	logic signed [31:0] x_s    [CORDIC_ITERS+1];
	logic signed [31:0] y_s    [CORDIC_ITERS+1];
	logic signed [31:0] z_s    [CORDIC_ITERS+1];
	ppwt_side_t         side_s [CORDIC_ITERS+1];

	logic               flip;
	logic        [31:0] ang;

	assign flip = in_word.heading[15] ^ in_word.heading[14];
	assign ang  = {in_word.heading ^ {flip, 15'd0}, 16'd0};

	// pre-rotation: fold the left half-plane onto the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= flip ? -GAIN_Q30 : GAIN_Q30;
		y_s[0]    <= 32'sd0;
		z_s[0]    <= signed'(ang);
		side_s[0] <= '{robot_x: in_word.robot_x, robot_y: in_word.robot_y,
			point_x: in_word.point_x, point_y: in_word.point_y};
	end

	for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (!z_s[k][31]) begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] - ATAN_TAB[k];
			end else begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] + ATAN_TAB[k];
			end
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = v_s[CORDIC_ITERS];
	assign out_side  = side_s[CORDIC_ITERS];
	assign cos_q     = x_s[CORDIC_ITERS];
	assign sin_q     = y_s[CORDIC_ITERS];

endmodule

### verif/testbench.sv
// Self-checking testbench for planar_pose_to_world_transform_core.
// Drives directed and random pose words and checks each result against a stated value or a CORDIC predictor.
// Depends on ppwt_pkg and the core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ppwt_pkg::*;

	localparam int RANDOM_WORDS = 700;
	localparam int CYCLE_LIMIT  = 60000;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		ppwt_in_t  pose;
		bit        known;
		ppwt_out_t want;
	} pose_row_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	ppwt_in_t  pose   = '0;
	logic      busy;
	logic      done;
	ppwt_out_t result;

	pose_row_t directed_rows[$];
	ppwt_out_t expected_words[$];
	ppwt_out_t want_word;
	int        mismatches = 0;
	int        unexpected = 0;
	int        checked    = 0;
	int        saturated  = 0;
	int        directed_sent = 0;
	int        random_sent   = 0;
	int        cycles     = 0;
	int        errors;

	planar_pose_to_world_transform_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pose   (pose),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void heading_cos_sin(input logic [15:0] hd,
			output longint signed c, output longint signed s);
		logic [31:0]   ang;
		longint signed x;
		longint signed y;
		longint signed z;
		longint signed dx;
		longint signed dy;
		ang = {hd, 16'h0000};
		x = GAIN_Q30;
		y = 0;
		if (hd[15:14] == 2'b01 || hd[15:14] == 2'b10) begin
			ang[31] = ~ang[31];
			x = -x;
		end
		z = $signed(ang);
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TAB[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TAB[i];
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic ppwt_out_t rotate_translate(input ppwt_in_t p);
		longint signed c;
		longint signed s;
		longint signed px;
		longint signed py;
		longint signed wx;
		longint signed wy;
		ppwt_out_t     w;
		heading_cos_sin(p.heading, c, s);
		px = p.point_x;
		py = p.point_y;
		wx = longint'(p.robot_x) + ((px * c - py * s + 64'sd536870912) >>> 30);
		wy = longint'(p.robot_y) + ((px * s + py * c + 64'sd536870912) >>> 30);
		w.overflowed = 1'b0;
		if (wx > longint'(SAT_MAX)) begin
			wx = SAT_MAX;
			w.overflowed = 1'b1;
		end else if (wx < longint'(SAT_MIN)) begin
			wx = SAT_MIN;
			w.overflowed = 1'b1;
		end
		if (wy > longint'(SAT_MAX)) begin
			wy = SAT_MAX;
			w.overflowed = 1'b1;
		end else if (wy < longint'(SAT_MIN)) begin
			wy = SAT_MIN;
			w.overflowed = 1'b1;
		end
		w.world_x = wx[31:0];
		w.world_y = wy[31:0];
		return w;
	endfunction

	function automatic ppwt_in_t make_pose(input logic signed [31:0] rx,
			input logic signed [31:0] ry, input logic [15:0] hd,
			input logic signed [31:0] px, input logic signed [31:0] py);
		ppwt_in_t p;
		p.robot_x = rx;
		p.robot_y = ry;
		p.heading = hd;
		p.point_x = px;
		p.point_y = py;
		return p;
	endfunction

	task automatic add_row(input ppwt_in_t p, input bit known,
			input logic signed [31:0] wx, input logic signed [31:0] wy, input logic ov);
		pose_row_t r;
		r.pose = p;
		r.known = known;
		r.want.world_x = wx;
		r.want.world_y = wy;
		r.want.overflowed = ov;
		directed_rows.push_back(r);
	endtask

	function automatic ppwt_in_t random_pose();
		ppwt_in_t p;
		int       kind;
		kind = $urandom_range(0, 99);
		p.heading = 16'($urandom_range(0, 65535));
		if (kind < 50) begin
			p.robot_x = $urandom;
			p.robot_y = $urandom;
			p.point_x = $urandom;
			p.point_y = $urandom;
		end else if (kind < 80) begin
			p.robot_x = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
			p.robot_y = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
			p.point_x = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			p.point_y = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		end else begin
			p.robot_x = $urandom_range(0, 1) ? SAT_MAX - int'($urandom_range(0, 32'h00FF_FFFF))
				: SAT_MIN + int'($urandom_range(0, 32'h00FF_FFFF));
			p.robot_y = $urandom_range(0, 1) ? SAT_MAX - int'($urandom_range(0, 32'h00FF_FFFF))
				: SAT_MIN + int'($urandom_range(0, 32'h00FF_FFFF));
			p.point_x = int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
			p.point_y = int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
		end
		return p;
	endfunction

	task automatic send_word(input ppwt_in_t p, input bit known, input ppwt_out_t want,
			input bit may_idle);
		if (may_idle && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pose  <= p;
		do @(posedge clk); while (busy);
		expected_words.push_back(known ? want : rotate_translate(p));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_words.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= MAX_REPORTS)
					$display("unexpected result: x=%h y=%h ov=%b",
						result.world_x, result.world_y, result.overflowed);
			end else begin
				want_word = expected_words.pop_front();
				checked++;
				if (result.overflowed)
					saturated++;
				if (result.world_x !== want_word.world_x || result.world_y !== want_word.world_y
						|| result.overflowed !== want_word.overflowed) begin
					mismatches++;
					if (mismatches + unexpected <= MAX_REPORTS)
						$display("result %0d: expected x=%h y=%h ov=%b, got x=%h y=%h ov=%b",
							checked, want_word.world_x, want_word.world_y,
							want_word.overflowed, result.world_x, result.world_y,
							result.overflowed);
				end
			end
		end
	end

	initial begin
		add_row(make_pose(0, 0, 16'h0000, 0, 0), 1'b1, 0, 0, 1'b0);
		add_row(make_pose(SAT_MAX, SAT_MIN, 16'h0000, 0, 0), 1'b1, SAT_MAX, SAT_MIN, 1'b0);
		add_row(make_pose(SAT_MIN, SAT_MAX, 16'h8000, 0, 0), 1'b1, SAT_MIN, SAT_MAX, 1'b0);
		add_row(make_pose(SAT_MAX, SAT_MAX, 16'h0000, SAT_MAX, SAT_MAX), 1'b1,
			SAT_MAX, SAT_MAX, 1'b1);
		add_row(make_pose(SAT_MIN, SAT_MIN, 16'h0000, SAT_MIN, SAT_MIN), 1'b1,
			SAT_MIN, SAT_MIN, 1'b1);
		add_row(make_pose(SAT_MAX, SAT_MAX, 16'h8000, SAT_MIN, SAT_MIN), 1'b1,
			SAT_MAX, SAT_MAX, 1'b1);
		add_row(make_pose(SAT_MAX, SAT_MAX, 16'h4000, SAT_MAX, SAT_MIN), 1'b1,
			SAT_MAX, SAT_MAX, 1'b1);
		add_row(make_pose(SAT_MIN, SAT_MIN, 16'hC000, SAT_MAX, SAT_MIN), 1'b1,
			SAT_MIN, SAT_MIN, 1'b1);
		add_row(make_pose(0, 0, 16'h0000, 32'sh0001_0000, 0), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'h2000, 32'sh0001_0000, 0), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'h3FFF, 32'sh0001_0000, 32'sh0002_0000), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'h4000, 32'sh0001_0000, 32'sh0002_0000), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'h4001, 32'sh0001_0000, 32'sh0002_0000), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'h7FFF, 32'sh0003_0000, -32'sh0001_0000), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'h8000, 32'sh0003_0000, -32'sh0001_0000), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'hBFFF, 32'sh0003_0000, -32'sh0001_0000), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'hC000, 32'sh0003_0000, -32'sh0001_0000), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'hFFFF, 32'sh0003_0000, -32'sh0001_0000), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(-1, -1, 16'hFFFF, -1, -1), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(SAT_MAX, 0, 16'h0000, 32'sh0001_0000, 32'sh0001_0000), 1'b0,
			0, 0, 1'b0);
		add_row(make_pose(0, SAT_MIN, 16'h0000, 0, -32'sh0001_0000), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(0, 0, 16'h6000, SAT_MAX, SAT_MIN), 1'b0, 0, 0, 1'b0);
		add_row(make_pose(32'sh1234_5678, -32'sh0765_4321, 16'h1000, 1, 1), 1'b0, 0, 0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].pose, directed_rows[i].known, directed_rows[i].want,
				1'b1);
			directed_sent++;
		end
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			send_word(random_pose(), 1'b0, '0, !(n >= 250 && n < 450));
			random_sent++;
		end
		start <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);

		errors = mismatches + unexpected + expected_words.size();
		$display("%0d words sent (%0d directed, %0d random), %0d results checked",
			directed_sent + random_sent, directed_sent, random_sent, checked);
		$display("%0d results saturated, %0d mismatched, %0d unexpected",
			saturated, mismatches, unexpected);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
hdl/ppwt_pkg.sv
hdl/ppwt_cordic.sv
hdl/planar_pose_to_world_transform_core.sv
verif/testbench.sv
